// ===== design/bucket_priority_ready_queue_defines.svh =====
// assertion macros for the bucket priority ready queue
`ifndef BUCKET_PRIORITY_READY_QUEUE_DEFINES_SVH
`define BUCKET_PRIORITY_READY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off during reset
`define BPQ_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("bucket queue check failed");
// next-cycle implication, sampled on clk_i, off during reset
`define BPQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("bucket queue check failed");
`else
`define BPQ_ASSERT_IMPL(lbl, pre, post)
`define BPQ_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== design/bpq_pkg.sv =====
// shared types, codes and defaults of the bucket priority ready queue
package bpq_pkg;

  // default sizes
  localparam int LevelsDef     = 50;
  localparam int CapacityDef   = 64;
  localparam int HandleBitsDef = 16;

  // request kinds
  localparam logic KindAdd    = 1'b0;
  localparam logic KindRemove = 1'b1;

  // result status codes
  localparam logic [2:0] StAdded   = 3'd0;
  localparam logic [2:0] StBadPrio = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StRemoved = 3'd3;
  localparam logic [2:0] StEmpty   = 3'd4;

  // input request
  typedef struct packed {
    logic        kind;
    logic [15:0] proc_handle;
    logic [5:0]  prio_level;
  } req_t;

  // result
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [5:0]  out_level;
    logic [6:0]  entry_count;
  } rsp_t;

  // row-wide command to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } ctrl_t;

endpackage

// ===== design/bpq_cell.sv =====
// one cell of the sorted entry row: holds one queued entry
module bpq_cell import bpq_pkg::*; #(
  parameter int HW = HandleBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ctrl_t         ctrl_i,
  input  logic [5:0]    new_level_i,
  input  logic [HW-1:0] new_handle_i,
  input  logic          left_gt_i,
  input  logic          left_valid_i,
  input  logic [5:0]    left_level_i,
  input  logic [HW-1:0] left_handle_i,
  input  logic          right_valid_i,
  input  logic [5:0]    right_level_i,
  input  logic [HW-1:0] right_handle_i,
  output logic          valid_o,
  output logic [5:0]    level_o,
  output logic [HW-1:0] handle_o,
  output logic          gt_o
);

  logic          valid_q, valid_d;
  logic [5:0]    level_q, level_d;
  logic [HW-1:0] handle_q, handle_d;

  // this entry stays ahead of a new one only if strictly more urgent
  assign gt_o = valid_q && (level_q > new_level_i);

  // insert: keep, take the new entry, or take the left neighbor; remove: shift left
  always_comb begin
    valid_d  = valid_q;
    level_d  = level_q;
    handle_d = handle_q;
    if (ctrl_i.ins) begin
      if (!gt_o) begin
        if (left_gt_i) begin
          valid_d  = 1'b1;
          level_d  = new_level_i;
          handle_d = new_handle_i;
        end else begin
          valid_d  = left_valid_i;
          level_d  = left_level_i;
          handle_d = left_handle_i;
        end
      end
    end else if (ctrl_i.rem) begin
      valid_d  = right_valid_i;
      level_d  = right_level_i;
      handle_d = right_handle_i;
    end
  end

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    level_q  <= level_d;
    handle_q <= handle_d;
  end

  assign valid_o  = valid_q;
  assign level_o  = level_q;
  assign handle_o = handle_q;

endmodule

// ===== design/bucket_priority_ready_queue.sv =====
// bucket priority ready queue: the result is registered and valid in the cycle after the request is accepted;
// throughput one request per cycle while results are taken; a remove shifts the whole row
// of entry cells at once, an add shifts only the cells behind its insert point; the output register
// parts the two sides
// reset clears every cell valid bit, the entry count and the output valid bit at once
`include "bucket_priority_ready_queue_defines.svh"
module bucket_priority_ready_queue import bpq_pkg::*; #(
  parameter int LEVELS      = LevelsDef,
  parameter int CAPACITY    = CapacityDef,
  parameter int HANDLE_BITS = HandleBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  localparam int SB   = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam logic [5:0]      LevelsV = 6'(LEVELS);
  localparam logic [CntW-1:0] CapV    = CntW'(CAPACITY);

  logic            out_valid_q;
  rsp_t            out_q;
  logic [CntW-1:0] count_q, count_d;
  logic            accept;
  logic            bad_prio, full;
  ctrl_t           ctrl;
  rsp_t            rsp_d;
  logic [SB-1:0]   new_handle;

  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_gt;
  logic [5:0]          cell_level  [CAPACITY];
  logic [SB-1:0]       cell_handle [CAPACITY];

  logic [CntW+6:0] cnt_ext;
  logic [SB+15:0]  hnd_ext;

  // handshake: take a request whenever the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // request decode
  assign bad_prio   = (in_req_i.prio_level == 6'd0) || (in_req_i.prio_level > LevelsV);
  assign full       = (count_q == CapV);
  assign new_handle = in_req_i.proc_handle[SB-1:0];
  assign ctrl.ins   = accept && (in_req_i.kind == KindAdd) && !bad_prio && !full;
  assign ctrl.rem   = accept && (in_req_i.kind == KindRemove) && (count_q != '0);

  // entry count
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.rem) begin
      count_d = count_q - 1'b1;
    end
  end

  assign cnt_ext = {7'd0, count_d};
  assign hnd_ext = {16'd0, cell_handle[0]};

  // result; the head cell holds the most urgent, newest entry
  always_comb begin
    rsp_d.status      = StAdded;
    rsp_d.out_handle  = '0;
    rsp_d.out_level   = '0;
    rsp_d.entry_count = cnt_ext[6:0];
    if (in_req_i.kind == KindAdd) begin
      if (bad_prio) begin
        rsp_d.status = StBadPrio;
      end else if (full) begin
        rsp_d.status = StFull;
      end
    end else begin
      if (count_q == '0) begin
        rsp_d.status = StEmpty;
      end else begin
        rsp_d.status     = StRemoved;
        rsp_d.out_handle = hnd_ext[15:0];
        rsp_d.out_level  = cell_level[0];
      end
    end
  end

  // row of entry cells, sorted by priority, newest first among equals
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          l_gt, l_valid, r_valid;
    logic [5:0]    l_level, r_level;
    logic [SB-1:0] l_handle, r_handle;

    if (i == 0) begin : g_head
      assign l_gt     = 1'b1;
      assign l_valid  = 1'b0;
      assign l_level  = '0;
      assign l_handle = '0;
    end else begin : g_mid
      assign l_gt     = cell_gt[i-1];
      assign l_valid  = cell_valid[i-1];
      assign l_level  = cell_level[i-1];
      assign l_handle = cell_handle[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid  = 1'b0;
      assign r_level  = '0;
      assign r_handle = '0;
    end else begin : g_body
      assign r_valid  = cell_valid[i+1];
      assign r_level  = cell_level[i+1];
      assign r_handle = cell_handle[i+1];
    end

    bpq_cell #(
      .HW (SB)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .new_level_i    (in_req_i.prio_level),
      .new_handle_i   (new_handle),
      .left_gt_i      (l_gt),
      .left_valid_i   (l_valid),
      .left_level_i   (l_level),
      .left_handle_i  (l_handle),
      .right_valid_i  (r_valid),
      .right_level_i  (r_level),
      .right_handle_i (r_handle),
      .valid_o        (cell_valid[i]),
      .level_o        (cell_level[i]),
      .handle_o       (cell_handle[i]),
      .gt_o           (cell_gt[i])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // checks
  `BPQ_ASSERT_IMPL(a_count_matches_cells, 1'b1, $countones(cell_valid) == count_q)
  `BPQ_ASSERT_IMPL(a_head_sorted, cell_valid[1], cell_level[0] >= cell_level[1])
  `BPQ_ASSERT_NEXT(a_remove_counts_down, ctrl.rem, count_q == $past(count_q) - 1'b1)

endmodule
